[hdl/bap_pkg.sv]
// shared types and constants for the block average pixelation core
`default_nettype none

package bap_pkg;

   localparam int PIX_W      = 8;
   localparam int CHANNELS   = 3;
   localparam int POS_W      = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int BSZ_REG_W  = 7;
   localparam int DIM_REG_W  = 12;

   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   typedef struct packed {
      logic [POS_W-1:0] block_column;
      logic [POS_W-1:0] block_row;
      logic             frame_end;
   } blk_info_type;

endpackage

`default_nettype wire

[hdl/bap_raster.sv]
// configuration registers and raster position counters
`default_nettype none

module bap_raster #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048,
   parameter int MAX_BLOCK  = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_wr_en,
   input  wire logic [bap_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [bap_pkg::CSR_DATA_W-1:0]         csr_data,
   input  wire logic                                   pix_accept,
   output logic [$clog2(MAX_WIDTH)-1:0]                pix_idx,
   output logic                                        pix_first,
   output logic                                        pix_last,
   output logic [$clog2(MAX_BLOCK*MAX_BLOCK+1)-1:0]    pix_cnt,
   output bap_pkg::blk_info_type                       pix_info
);

   localparam int CIBW = $clog2(MAX_BLOCK);
   localparam int BSW  = $clog2(MAX_BLOCK + 1);
   localparam int PCW  = $clog2(MAX_WIDTH);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int PRW  = $clog2(MAX_HEIGHT);
   localparam int HHW  = $clog2(MAX_HEIGHT + 1);
   localparam int CW   = $clog2(MAX_BLOCK * MAX_BLOCK + 1);

   logic [bap_pkg::BSZ_REG_W-1:0] bsz_ff, bsz_in;
   logic [bap_pkg::DIM_REG_W-1:0] wid_ff, wid_in;
   logic [bap_pkg::DIM_REG_W-1:0] hgt_ff, hgt_in;
   logic                          restart;

   logic [PCW-1:0]  pc_ff, pc_in;
   logic [PRW-1:0]  pr_ff, pr_in;
   logic [CIBW-1:0] cib_ff, cib_in;
   logic [CIBW-1:0] rib_ff, rib_in;
   logic [PCW-1:0]  bc_ff, bc_in;
   logic [PRW-1:0]  br_ff, br_in;

   logic [BSW-1:0] bs;
   logic [WW-1:0]  w;
   logic [HHW-1:0] h;
   logic [BSW-1:0] cib_p1, rib_p1;
   logic [WW-1:0]  pc_p1;
   logic [HHW-1:0] pr_p1;
   logic           col_blk_end, row_blk_end, line_end, last_line, frame_end;

   // effective sizes: zero acts as one, large values saturate
   always_comb begin
      if (bsz_ff == '0) begin
         bs = BSW'(1);
      end else if (32'(bsz_ff) > MAX_BLOCK) begin
         bs = BSW'(MAX_BLOCK);
      end else begin
         bs = BSW'(bsz_ff);
      end
      if (wid_ff == '0) begin
         w = WW'(1);
      end else if (32'(wid_ff) > MAX_WIDTH) begin
         w = WW'(MAX_WIDTH);
      end else begin
         w = WW'(wid_ff);
      end
      if (hgt_ff == '0) begin
         h = HHW'(1);
      end else if (32'(hgt_ff) > MAX_HEIGHT) begin
         h = HHW'(MAX_HEIGHT);
      end else begin
         h = HHW'(hgt_ff);
      end
   end

   assign cib_p1      = BSW'(cib_ff) + BSW'(1);
   assign rib_p1      = BSW'(rib_ff) + BSW'(1);
   assign pc_p1       = WW'(pc_ff) + WW'(1);
   assign pr_p1       = HHW'(pr_ff) + HHW'(1);
   assign col_blk_end = cib_p1 >= bs;
   assign row_blk_end = rib_p1 >= bs;
   assign line_end    = pc_p1 >= w;
   assign last_line   = pr_p1 >= h;
   assign frame_end   = line_end && last_line;

   assign pix_idx   = bc_ff;
   assign pix_first = (cib_ff == '0) && (rib_ff == '0);
   assign pix_last  = (col_blk_end || line_end) && (row_blk_end || last_line);
   assign pix_cnt   = CW'(cib_p1) * CW'(rib_p1);

   assign pix_info.block_column = bap_pkg::POS_W'(bc_ff);
   assign pix_info.block_row    = bap_pkg::POS_W'(br_ff);
   assign pix_info.frame_end    = frame_end;

   always_comb begin
      bsz_in  = bsz_ff;
      wid_in  = wid_ff;
      hgt_in  = hgt_ff;
      restart = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            bap_pkg::REG_BLOCK_SIZE: begin
               bsz_in  = csr_data[bap_pkg::BSZ_REG_W-1:0];
               restart = 1'b1;
            end
            bap_pkg::REG_IMAGE_WIDTH: begin
               wid_in  = csr_data;
               restart = 1'b1;
            end
            bap_pkg::REG_IMAGE_HEIGHT: begin
               hgt_in  = csr_data;
               restart = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      pc_in  = pc_ff;
      pr_in  = pr_ff;
      cib_in = cib_ff;
      rib_in = rib_ff;
      bc_in  = bc_ff;
      br_in  = br_ff;
      if (restart || (pix_accept && frame_end)) begin
         pc_in  = '0;
         pr_in  = '0;
         cib_in = '0;
         rib_in = '0;
         bc_in  = '0;
         br_in  = '0;
      end else if (pix_accept) begin
         if (line_end) begin
            pc_in  = '0;
            cib_in = '0;
            bc_in  = '0;
            pr_in  = PRW'(pr_p1);
            if (row_blk_end) begin
               rib_in = '0;
               br_in  = br_ff + PRW'(1);
            end else begin
               rib_in = CIBW'(rib_p1);
            end
         end else begin
            pc_in = PCW'(pc_p1);
            if (col_blk_end) begin
               cib_in = '0;
               bc_in  = bc_ff + PCW'(1);
            end else begin
               cib_in = CIBW'(cib_p1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bsz_ff <= bap_pkg::BSZ_REG_W'(8);
         wid_ff <= bap_pkg::DIM_REG_W'(640);
         hgt_ff <= bap_pkg::DIM_REG_W'(480);
         pc_ff  <= '0;
         pr_ff  <= '0;
         cib_ff <= '0;
         rib_ff <= '0;
         bc_ff  <= '0;
         br_ff  <= '0;
      end else begin
         bsz_ff <= bsz_in;
         wid_ff <= wid_in;
         hgt_ff <= hgt_in;
         pc_ff  <= pc_in;
         pr_ff  <= pr_in;
         cib_ff <= cib_in;
         rib_ff <= rib_in;
         bc_ff  <= bc_in;
         br_ff  <= br_in;
      end
   end

endmodule

`default_nettype wire

[hdl/bap_accum.sv]
// per block column sum memory with read-modify-write and forwarding
`default_nettype none

module bap_accum #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_BLOCK = 64
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          in_valid,
   output logic                                               in_ready,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]                  in_idx,
   input  wire logic                                          in_first,
   input  wire logic                                          in_last,
   input  wire logic [$clog2(MAX_BLOCK*MAX_BLOCK+1)-1:0]      in_cnt,
   input  wire bap_pkg::blk_info_type                         in_info,
   input  wire logic [bap_pkg::CHANNELS-1:0][bap_pkg::PIX_W-1:0] in_pix,
   output logic                                               out_valid,
   input  wire logic                                          out_ready,
   output logic [$clog2(MAX_BLOCK*MAX_BLOCK+1)-1:0]           out_cnt,
   output bap_pkg::blk_info_type                              out_info,
   output logic [bap_pkg::CHANNELS-1:0]
                [bap_pkg::PIX_W+$clog2(MAX_BLOCK*MAX_BLOCK+1)-1:0] out_sum
);

   localparam int PCW   = $clog2(MAX_WIDTH);
   localparam int CW    = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
   localparam int SW    = bap_pkg::PIX_W + CW;
   localparam int DEPTH = MAX_WIDTH;

   logic [bap_pkg::CHANNELS-1:0][SW-1:0] sum_mem [DEPTH];
   logic [bap_pkg::CHANNELS-1:0][SW-1:0] rd_ff;

   logic                                        s1_valid_ff, s1_valid_in;
   logic [PCW-1:0]                              s1_idx_ff;
   logic                                        s1_first_ff;
   logic                                        s1_last_ff;
   logic [CW-1:0]                               s1_cnt_ff;
   bap_pkg::blk_info_type                       s1_info_ff;
   logic [bap_pkg::CHANNELS-1:0][bap_pkg::PIX_W-1:0] s1_pix_ff;

   logic                                 wb_valid_ff, wb_valid_in;
   logic [PCW-1:0]                       wb_idx_ff;
   logic [bap_pkg::CHANNELS-1:0][SW-1:0] wb_sum_ff;

   logic                                 s1_ready, accept, wr_en, fwd;
   logic [bap_pkg::CHANNELS-1:0][SW-1:0] base, new_sum;

   assign s1_ready = !s1_valid_ff || !s1_last_ff || out_ready;
   assign in_ready = s1_ready;
   assign accept   = in_valid && s1_ready;
   assign wr_en    = s1_valid_ff && s1_ready;

   // the previous write may land in memory on the same edge this read is taken
   assign fwd = wb_valid_ff && (wb_idx_ff == s1_idx_ff);

   always_comb begin
      for (int ch = 0; ch < bap_pkg::CHANNELS; ch++) begin
         if (s1_first_ff) begin
            base[ch] = '0;
         end else if (fwd) begin
            base[ch] = wb_sum_ff[ch];
         end else begin
            base[ch] = rd_ff[ch];
         end
         new_sum[ch] = base[ch] + SW'(s1_pix_ff[ch]);
      end
   end

   assign out_valid = s1_valid_ff && s1_last_ff;
   assign out_cnt   = s1_cnt_ff;
   assign out_info  = s1_info_ff;
   assign out_sum   = new_sum;

   assign s1_valid_in = accept ? 1'b1 : (s1_ready ? 1'b0 : s1_valid_ff);
   assign wb_valid_in = wb_valid_ff || wr_en;

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= sum_mem[in_idx];
      end
      if (wr_en) begin
         sum_mem[s1_idx_ff] <= new_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wb_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         wb_valid_ff <= wb_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff   <= in_idx;
         s1_first_ff <= in_first;
         s1_last_ff  <= in_last;
         s1_cnt_ff   <= in_cnt;
         s1_info_ff  <= in_info;
         s1_pix_ff   <= in_pix;
      end
      if (wr_en) begin
         wb_idx_ff <= s1_idx_ff;
         wb_sum_ff <= new_sum;
      end
   end

endmodule

`default_nettype wire

[hdl/bap_div.sv]
// pipelined restoring divider, one quotient bit per stage for all channels
`default_nettype none

module bap_div #(
   parameter int MAX_BLOCK = 64
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          in_valid,
   output logic                                               in_ready,
   input  wire logic [$clog2(MAX_BLOCK*MAX_BLOCK+1)-1:0]      in_cnt,
   input  wire bap_pkg::blk_info_type                         in_info,
   input  wire logic [bap_pkg::CHANNELS-1:0]
                     [bap_pkg::PIX_W+$clog2(MAX_BLOCK*MAX_BLOCK+1)-1:0] in_sum,
   output logic                                               out_valid,
   input  wire logic                                          out_ready,
   output bap_pkg::blk_info_type                              out_info,
   output logic [bap_pkg::CHANNELS-1:0][bap_pkg::PIX_W-1:0]   out_mean
);

   localparam int CW  = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
   localparam int SW  = bap_pkg::PIX_W + CW;
   localparam int NST = bap_pkg::PIX_W;

   logic [NST-1:0]                                    v_ff;
   logic [NST:0]                                      rdy;
   logic [CW-1:0]                                     cnt_ff  [NST];
   bap_pkg::blk_info_type                             info_ff [NST];
   logic [bap_pkg::CHANNELS-1:0][SW-1:0]              rem_ff  [NST];
   logic [bap_pkg::CHANNELS-1:0][bap_pkg::PIX_W-1:0]  q_ff    [NST];

   assign rdy[NST]  = out_ready;
   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NST-1];
   assign out_info  = info_ff[NST-1];
   assign out_mean  = q_ff[NST-1];

   for (genvar s = 0; s < NST; s++) begin : g_stage
      logic                                             v_src;
      logic [CW-1:0]                                    c_src;
      bap_pkg::blk_info_type                            i_src;
      logic [bap_pkg::CHANNELS-1:0][SW-1:0]             r_src, r_in;
      logic [bap_pkg::CHANNELS-1:0][bap_pkg::PIX_W-1:0] q_src, q_in;
      logic [SW-1:0]                                    trial;

      if (s == 0) begin : g_head
         assign v_src = in_valid;
         assign c_src = in_cnt;
         assign i_src = in_info;
         assign r_src = in_sum;
         assign q_src = '0;
      end else begin : g_body
         assign v_src = v_ff[s-1];
         assign c_src = cnt_ff[s-1];
         assign i_src = info_ff[s-1];
         assign r_src = rem_ff[s-1];
         assign q_src = q_ff[s-1];
      end

      assign rdy[s] = !v_ff[s] || rdy[s+1];
      assign trial  = SW'(c_src) << (NST - 1 - s);

      always_comb begin
         r_in = r_src;
         q_in = q_src;
         for (int ch = 0; ch < bap_pkg::CHANNELS; ch++) begin
            if (r_src[ch] >= trial) begin
               r_in[ch]             = r_src[ch] - trial;
               q_in[ch][NST-1-s]    = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            v_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s] && v_src) begin
            cnt_ff[s]  <= c_src;
            info_ff[s] <= i_src;
            rem_ff[s]  <= r_in;
            q_ff[s]    <= q_in;
         end
      end
   end

endmodule

`default_nettype wire

[hdl/block_average_pixelation_core.sv]
// top level of the block average pixelation core
//
// Pixels enter in raster order, one per clock cycle sustained; the only
// loop is the read-modify-write of the per block column sum memory,
// closed by forwarding the last write back into the adder. When the
// bottom-right pixel of a block (clipped at the image edges) is taken, the
// block's three channel sums go through an eight stage divider, one quotient
// bit per stage, and the block result is presented once the sums have passed
// the accumulator input register and every divider stage. Input stalls only
// when results back up through the divider pipeline. The sum memory is not
// cleared after reset: each entry is written by the first pixel of its block
// before it is read. Block size, width and height writes restart the frame.
`default_nettype none

module block_average_pixelation_core #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048,
   parameter int MAX_BLOCK  = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [bap_pkg::PIX_W-1:0]          req_red,
   input  wire logic [bap_pkg::PIX_W-1:0]          req_green,
   input  wire logic [bap_pkg::PIX_W-1:0]          req_blue,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [bap_pkg::POS_W-1:0]               rsp_block_column,
   output logic [bap_pkg::POS_W-1:0]               rsp_block_row,
   output logic [bap_pkg::PIX_W-1:0]               rsp_mean_red,
   output logic [bap_pkg::PIX_W-1:0]               rsp_mean_green,
   output logic [bap_pkg::PIX_W-1:0]               rsp_mean_blue,
   output logic                                    rsp_frame_end,
   input  wire logic                               csr_wr_en,
   input  wire logic [bap_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [bap_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int PCW = $clog2(MAX_WIDTH);
   localparam int CW  = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
   localparam int SW  = bap_pkg::PIX_W + CW;

   logic                                             pix_accept;
   logic [PCW-1:0]                                   pix_idx;
   logic                                             pix_first, pix_last;
   logic [CW-1:0]                                    pix_cnt;
   bap_pkg::blk_info_type                            pix_info;
   logic [bap_pkg::CHANNELS-1:0][bap_pkg::PIX_W-1:0] pix;

   logic                                             acc_valid, div_ready;
   logic [CW-1:0]                                    acc_cnt;
   bap_pkg::blk_info_type                            acc_info;
   logic [bap_pkg::CHANNELS-1:0][SW-1:0]             acc_sum;

   bap_pkg::blk_info_type                            res_info;
   logic [bap_pkg::CHANNELS-1:0][bap_pkg::PIX_W-1:0] res_mean;

   assign pix_accept            = req_valid && req_ready;
   assign pix[bap_pkg::CH_RED]   = req_red;
   assign pix[bap_pkg::CH_GREEN] = req_green;
   assign pix[bap_pkg::CH_BLUE]  = req_blue;

   bap_raster #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_BLOCK  (MAX_BLOCK)
   ) u_raster (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .pix_accept (pix_accept),
      .pix_idx    (pix_idx),
      .pix_first  (pix_first),
      .pix_last   (pix_last),
      .pix_cnt    (pix_cnt),
      .pix_info   (pix_info)
   );

   bap_accum #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_idx    (pix_idx),
      .in_first  (pix_first),
      .in_last   (pix_last),
      .in_cnt    (pix_cnt),
      .in_info   (pix_info),
      .in_pix    (pix),
      .out_valid (acc_valid),
      .out_ready (div_ready),
      .out_cnt   (acc_cnt),
      .out_info  (acc_info),
      .out_sum   (acc_sum)
   );

   bap_div #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (acc_valid),
      .in_ready  (div_ready),
      .in_cnt    (acc_cnt),
      .in_info   (acc_info),
      .in_sum    (acc_sum),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_info  (res_info),
      .out_mean  (res_mean)
   );

   assign rsp_block_column = res_info.block_column;
   assign rsp_block_row    = res_info.block_row;
   assign rsp_frame_end    = res_info.frame_end;
   assign rsp_mean_red     = res_mean[bap_pkg::CH_RED];
   assign rsp_mean_green   = res_mean[bap_pkg::CH_GREEN];
   assign rsp_mean_blue    = res_mean[bap_pkg::CH_BLUE];

endmodule

`default_nettype wire

[tb/block_average_pixelation_core_tb.sv]
// self-checking testbench for the block average pixelation core
module block_average_pixelation_core_tb;

   localparam int MAX_WIDTH     = 2048;
   localparam int MAX_HEIGHT    = 2048;
   localparam int MAX_BLOCK     = 64;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 200;
   localparam int RANDOM_PIXELS = 180;
   localparam int PHASE_CAP     = 60;
   localparam int PRINT_CAP     = 50;
   localparam logic [bap_pkg::CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [bap_pkg::PIX_W-1:0] red;
      logic [bap_pkg::PIX_W-1:0] green;
      logic [bap_pkg::PIX_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [bap_pkg::POS_W-1:0] block_column;
      logic [bap_pkg::POS_W-1:0] block_row;
      logic [bap_pkg::PIX_W-1:0] mean_red;
      logic [bap_pkg::PIX_W-1:0] mean_green;
      logic [bap_pkg::PIX_W-1:0] mean_blue;
      logic                      frame_end;
   } block_mean_type;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [bap_pkg::PIX_W-1:0]      req_red   = '0;
   logic [bap_pkg::PIX_W-1:0]      req_green = '0;
   logic [bap_pkg::PIX_W-1:0]      req_blue  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [bap_pkg::POS_W-1:0]      rsp_block_column;
   logic [bap_pkg::POS_W-1:0]      rsp_block_row;
   logic [bap_pkg::PIX_W-1:0]      rsp_mean_red;
   logic [bap_pkg::PIX_W-1:0]      rsp_mean_green;
   logic [bap_pkg::PIX_W-1:0]      rsp_mean_blue;
   logic                           rsp_frame_end;
   logic                           csr_wr_en = 1'b0;
   logic [bap_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [bap_pkg::CSR_DATA_W-1:0] csr_data  = '0;

   // predictor copy of the registers and raster position
   logic [bap_pkg::BSZ_REG_W-1:0] cfg_block  = 7'd8;
   logic [bap_pkg::DIM_REG_W-1:0] cfg_width  = 12'd640;
   logic [bap_pkg::DIM_REG_W-1:0] cfg_height = 12'd480;
   int unsigned pix_col = 0, pix_row = 0, col_in_blk = 0, row_in_blk = 0;
   int unsigned blk_col = 0, blk_row = 0;
   int unsigned chan_sum [bap_pkg::CHANNELS][MAX_WIDTH];

   pixel_type      pending_pixels [$];
   block_mean_type expected_means [$];

   logic           tx_busy = 1'b0;
   logic           tx_idle_on = 1'b1;
   logic           rx_idle_on = 1'b1;
   logic           rx_go;
   pixel_type      tx_pixel;
   block_mean_type rx_want;
   int unsigned tx_gap = 0, rx_stall = 0, hold_left = 0, hold_seq = 0, hold_seen = 0;
   int unsigned pixels_taken = 0, means_checked = 0, frames_seen = 0;
   int unsigned csr_writes = 0, error_count = 0;

   block_average_pixelation_core #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_BLOCK (MAX_BLOCK)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_block_column(rsp_block_column),
      .rsp_block_row   (rsp_block_row),
      .rsp_mean_red    (rsp_mean_red),
      .rsp_mean_green  (rsp_mean_green),
      .rsp_mean_blue   (rsp_mean_blue),
      .rsp_frame_end   (rsp_frame_end),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("block_average_pixelation_core_tb: FAIL");
      $finish;
   end

   task automatic flag_error(input string msg);
      if (error_count < PRINT_CAP) $display("ERROR: %0s", msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         flag_error($sformatf("%0s expected %0d got %0d (block %0d,%0d)", name, want, got,
                              rx_want.block_column, rx_want.block_row));
      end
   endtask

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned limit);
      if (v == 0) return 1;
      return (v > limit) ? limit : v;
   endfunction

   function automatic void restart_raster();
      pix_col    = 0;
      pix_row    = 0;
      col_in_blk = 0;
      row_in_blk = 0;
      blk_col    = 0;
      blk_row    = 0;
   endfunction

   // accumulate one pixel and queue the block mean it completes, if any
   function automatic void predict_block_mean(input pixel_type px);
      int unsigned    bs, w, h, idx, cnt;
      logic           last_col, last_row;
      block_mean_type m;
      bs  = clamp_dim(32'(cfg_block), MAX_BLOCK);
      w   = clamp_dim(32'(cfg_width), MAX_WIDTH);
      h   = clamp_dim(32'(cfg_height), MAX_HEIGHT);
      idx = (blk_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : blk_col;
      if (col_in_blk == 0 && row_in_blk == 0) begin
         chan_sum[bap_pkg::CH_RED][idx]   = 32'(px.red);
         chan_sum[bap_pkg::CH_GREEN][idx] = 32'(px.green);
         chan_sum[bap_pkg::CH_BLUE][idx]  = 32'(px.blue);
      end else begin
         chan_sum[bap_pkg::CH_RED][idx]   += 32'(px.red);
         chan_sum[bap_pkg::CH_GREEN][idx] += 32'(px.green);
         chan_sum[bap_pkg::CH_BLUE][idx]  += 32'(px.blue);
      end
      last_col = (col_in_blk + 1 >= bs) || (pix_col + 1 >= w);
      last_row = (row_in_blk + 1 >= bs) || (pix_row + 1 >= h);
      if (last_col && last_row) begin
         cnt            = (col_in_blk + 1) * (row_in_blk + 1);
         m.block_column = blk_col[bap_pkg::POS_W-1:0];
         m.block_row    = blk_row[bap_pkg::POS_W-1:0];
         m.mean_red     = bap_pkg::PIX_W'(chan_sum[bap_pkg::CH_RED][idx] / cnt);
         m.mean_green   = bap_pkg::PIX_W'(chan_sum[bap_pkg::CH_GREEN][idx] / cnt);
         m.mean_blue    = bap_pkg::PIX_W'(chan_sum[bap_pkg::CH_BLUE][idx] / cnt);
         m.frame_end    = (pix_col + 1 >= w) && (pix_row + 1 >= h);
         expected_means.push_back(m);
      end
      pix_col++;
      col_in_blk++;
      if (col_in_blk >= bs) begin
         col_in_blk = 0;
         blk_col++;
      end
      if (pix_col >= w) begin
         pix_col    = 0;
         col_in_blk = 0;
         blk_col    = 0;
         pix_row++;
         row_in_blk++;
         if (row_in_blk >= bs) begin
            row_in_blk = 0;
            blk_row++;
         end
         if (pix_row >= h) restart_raster();
      end
   endfunction

   function automatic logic [bap_pkg::PIX_W-1:0] channel_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return bap_pkg::PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void queue_pixel(input logic [bap_pkg::PIX_W-1:0] r,
                                       input logic [bap_pkg::PIX_W-1:0] g,
                                       input logic [bap_pkg::PIX_W-1:0] b);
      pixel_type px;
      px.red   = r;
      px.green = g;
      px.blue  = b;
      pending_pixels.push_back(px);
   endfunction

   function automatic void queue_random_pixels(input int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         queue_pixel(channel_value(), channel_value(), channel_value());
      end
   endfunction

   task automatic write_csr(input logic [bap_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bap_pkg::CSR_DATA_W-1:0] value);
      logic listed;
      listed = 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         bap_pkg::REG_BLOCK_SIZE:   cfg_block  = value[bap_pkg::BSZ_REG_W-1:0];
         bap_pkg::REG_IMAGE_WIDTH:  cfg_width  = value;
         bap_pkg::REG_IMAGE_HEIGHT: cfg_height = value;
         default:                   listed     = 1'b0;
      endcase
      if (listed) restart_raster();
      csr_writes++;
   endtask

   task automatic set_geometry(input logic [bap_pkg::CSR_DATA_W-1:0] bs,
                               input logic [bap_pkg::CSR_DATA_W-1:0] w,
                               input logic [bap_pkg::CSR_DATA_W-1:0] h);
      write_csr(bap_pkg::REG_BLOCK_SIZE, bs);
      write_csr(bap_pkg::REG_IMAGE_WIDTH, w);
      write_csr(bap_pkg::REG_IMAGE_HEIGHT, h);
   endtask

   // wait until every request is taken and every block mean has come back
   task automatic drain();
      while (pending_pixels.size() != 0 || tx_busy || expected_means.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         tx_busy = 1'b0;
         tx_gap  = 0;
         req_valid <= 1'b0;
      end else begin
         if (tx_busy && req_ready) begin
            predict_block_mean(tx_pixel);
            pixels_taken++;
            tx_busy = 1'b0;
            if (tx_idle_on && $urandom_range(0, 3) == 0) tx_gap = $urandom_range(1, 7);
         end
         if (!tx_busy) begin
            if (tx_gap > 0) begin
               tx_gap--;
            end else if (pending_pixels.size() != 0) begin
               tx_pixel = pending_pixels.pop_front();
               tx_busy  = 1'b1;
               req_red   <= tx_pixel.red;
               req_green <= tx_pixel.green;
               req_blue  <= tx_pixel.blue;
            end
         end
         req_valid <= tx_busy;
      end
   end

   // block mean monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_means.size() == 0) begin
               flag_error($sformatf("unexpected block mean at column %0d row %0d",
                                    rsp_block_column, rsp_block_row));
            end else begin
               rx_want = expected_means.pop_front();
               check_field("block_column", 16'(rx_want.block_column), 16'(rsp_block_column));
               check_field("block_row", 16'(rx_want.block_row), 16'(rsp_block_row));
               check_field("mean_red", 16'(rx_want.mean_red), 16'(rsp_mean_red));
               check_field("mean_green", 16'(rx_want.mean_green), 16'(rsp_mean_green));
               check_field("mean_blue", 16'(rx_want.mean_blue), 16'(rsp_mean_blue));
               check_field("frame_end", 16'(rx_want.frame_end), 16'(rsp_frame_end));
               means_checked++;
               if (rx_want.frame_end) frames_seen++;
            end
         end
         if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rx_go = 1'b0;
         end else if (rx_stall > 0) begin
            rx_stall--;
            rx_go = 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            rx_stall = $urandom_range(0, 6);
            rx_go    = 1'b0;
         end else begin
            rx_go = 1'b1;
         end
         rsp_ready <= rx_go;
      end
   end

   initial begin
      int unsigned n, wh, random_pixels;
      logic [bap_pkg::CSR_DATA_W-1:0] b_val, w_val, h_val;
      logic first_random;
      random_pixels = 0;
      first_random  = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default block size over a small frame, full scale then mixed
      write_csr(bap_pkg::REG_IMAGE_WIDTH, 12'd2);
      write_csr(bap_pkg::REG_IMAGE_HEIGHT, 12'd3);
      repeat (6) queue_pixel(8'hFF, 8'hFF, 8'hFF);
      queue_pixel(8'h00, 8'hFF, 8'h01);
      queue_pixel(8'h00, 8'hFF, 8'h02);
      queue_pixel(8'h00, 8'hFF, 8'h04);
      queue_pixel(8'h00, 8'hFF, 8'h08);
      queue_pixel(8'h00, 8'hFF, 8'h10);
      queue_pixel(8'h00, 8'hFF, 8'h20);
      drain();

      // zero registers behave as one
      set_geometry(12'd0, 12'd0, 12'd0);
      queue_pixel(8'hFF, 8'h00, 8'hAA);
      queue_pixel(8'h00, 8'hFF, 8'h55);
      drain();

      // clipped edge blocks with an ignored register write mid-frame
      set_geometry(12'd2, 12'd3, 12'd3);
      queue_random_pixels(4);
      drain();
      write_csr(REG_UNUSED, 12'hFFF);
      queue_random_pixels(5);
      drain();

      // oversized block size saturates
      set_geometry(12'd100, 12'd70, 12'd1);
      queue_random_pixels(70);
      drain();

      // long receiver hold so the core backs up into its input
      set_geometry(12'd1, 12'd8, 12'd8);
      hold_seq++;
      queue_random_pixels(64);
      drain();

      while (random_pixels < RANDOM_PIXELS) begin
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0: b_val = bap_pkg::CSR_DATA_W'($urandom_range(0, 31) << bap_pkg::BSZ_REG_W);
            1: b_val = bap_pkg::CSR_DATA_W'(($urandom_range(0, 31) << bap_pkg::BSZ_REG_W) |
                                            $urandom_range(65, 127));
            default: b_val = bap_pkg::CSR_DATA_W'($urandom_range(1, 6));
         endcase
         case ($urandom_range(0, 9))
            0:       w_val = 12'd0;
            1:       w_val = ($urandom_range(0, 1) != 0) ? 12'h800 : 12'hFFF;
            default: w_val = bap_pkg::CSR_DATA_W'($urandom_range(1, 20));
         endcase
         h_val = bap_pkg::CSR_DATA_W'($urandom_range(0, 8));
         if (first_random || $urandom_range(0, 1) != 0)
            write_csr(bap_pkg::REG_BLOCK_SIZE, b_val);
         if (first_random || $urandom_range(0, 1) != 0)
            write_csr(bap_pkg::REG_IMAGE_WIDTH, w_val);
         if (first_random || $urandom_range(0, 1) != 0)
            write_csr(bap_pkg::REG_IMAGE_HEIGHT, h_val);
         if ($urandom_range(0, 5) == 0)
            write_csr(REG_UNUSED, bap_pkg::CSR_DATA_W'($urandom_range(0, 4095)));
         first_random = 1'b0;
         wh = clamp_dim(32'(cfg_width), MAX_WIDTH) * clamp_dim(32'(cfg_height), MAX_HEIGHT);
         if (wh <= PHASE_CAP && $urandom_range(0, 2) != 0)
            n = wh * $urandom_range(1, 2);
         else
            n = $urandom_range(1, (wh < PHASE_CAP) ? wh : PHASE_CAP);
         queue_random_pixels(n);
         random_pixels += n;
         drain();
      end

      // closing stretch at full rate on both sides
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      set_geometry(12'd3, 12'd7, 12'd5);
      queue_random_pixels(70);
      drain();

      $display("covered %0d pixels and %0d register writes across many frame geometries",
               pixels_taken, csr_writes);
      $display("checked %0d block means, %0d of them closing a frame",
               means_checked, frames_seen);
      if (error_count == 0) begin
         $display("block_average_pixelation_core_tb: PASS");
      end else begin
         $display("block_average_pixelation_core_tb: FAIL");
      end
      $finish;
   end

endmodule
